### sv/llpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llpt_pkg
// Shared types, register indexes, and rounding and saturation helpers for the
// laser line point triangulation pipeline.
// ----------------------------------------------------------------------------
package llpt_pkg;

  typedef enum logic [3:0] {
    REG_FOCAL     = 4'd0,
    REG_WORK_DIST = 4'd1,
    REG_SIN_LEFT  = 4'd2,
    REG_COS_LEFT  = 4'd3,
    REG_SIN_RIGHT = 4'd4,
    REG_COS_RIGHT = 4'd5,
    REG_SIN_TURN  = 4'd6,
    REG_COS_TURN  = 4'd7
  } cfg_idx_t;

  localparam int RND_IW = 57;
  localparam int RND_OW = 43;
  localparam int RHO_W  = 39;
  localparam int RHO_MW = 38;
  localparam int XY_W   = 40;
  localparam int OUT_W  = 24;

  localparam logic signed [RND_OW-1:0] OUT_MAX = 43'sd8388607;
  localparam logic signed [RND_OW-1:0] OUT_MIN = -43'sd8388608;

  typedef struct packed {
    logic              clip;
    logic [OUT_W-1:0]  val;
  } sat_t;

  // p / 32768, rounded to nearest, halves away from zero
  function automatic logic signed [RND_OW-1:0] rnd15(input logic signed [RND_IW-1:0] p);
    logic [RND_IW-1:0] mag;
    logic [RND_IW-1:0] sum;
    logic [RND_OW-1:0] r;
    mag = p[RND_IW-1] ? RND_IW'(-p) : RND_IW'(p);
    sum = mag + RND_IW'(16384);
    r   = RND_OW'(sum >> 15);
    rnd15 = p[RND_IW-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic sat_t sat24(input logic signed [RND_OW-1:0] v);
    sat_t s;
    if (v > OUT_MAX) begin
      s.clip = 1'b1;
      s.val  = OUT_MAX[OUT_W-1:0];
    end else if (v < OUT_MIN) begin
      s.clip = 1'b1;
      s.val  = OUT_MIN[OUT_W-1:0];
    end else begin
      s.clip = 1'b0;
      s.val  = v[OUT_W-1:0];
    end
    sat24 = s;
  endfunction

endpackage
`default_nettype wire

### sv/laser_line_point_triangulation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// laser_line_point_triangulation
// Triangulates one laser-line pixel into a turntable-rotated 3D point.
// ----------------------------------------------------------------------------
// Fully pipelined: one pixel can be started every clock and busy never rises.
// Each result appears on done after its start, delayed mostly by the two
// bit-serial divider pipelines, one for the range (PIXEL_WIDTH + 44 stages)
// and one for the height (PIXEL_WIDTH + 50 stages). The receiver cannot stall
// the block, so results must be taken on the cycle done is high. Configuration
// should only be written while no pixel is in flight.
module laser_line_point_triangulation
  import llpt_pkg::*;
#(
  parameter int PIXEL_WIDTH = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [PIXEL_WIDTH-1:0] pix_x,
  input  logic signed [PIXEL_WIDTH-1:0] pix_y,
  input  logic                          right_side,
  output logic                          done,
  output logic signed [23:0]            point_x,
  output logic signed [23:0]            point_y,
  output logic signed [23:0]            point_z,
  output logic                          side_out,
  output logic                          clipped,
  input  logic                          cfg_we,
  input  logic [3:0]                    cfg_index,
  input  logic [23:0]                   cfg_data
);

  localparam int PW   = PIXEL_WIDTH;
  localparam int DENW = (PW + 26 > 42) ? PW + 26 : 42;
  localparam int UNW  = PW + 43;
  localparam int N1W  = UNW + 1;
  localparam int ZPW  = PW + 41;
  localparam int ZNW  = ZPW + 8;
  localparam int N2W  = ZNW + 1;
  localparam int T1W  = PW + 3;
  localparam int T2W  = 2 * OUT_W + 4;
  localparam int LAT  = 4 + N1W + 7 + N2W + 1;

  // configuration registers
  logic [23:0]        focal_pixels;
  logic [19:0]        work_dist;
  logic signed [15:0] sin_left, cos_left, sin_right, cos_right, sin_turn, cos_turn;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_pixels <= '0;
      work_dist    <= '0;
      sin_left     <= '0;
      cos_left     <= 16'sd32767;
      sin_right    <= '0;
      cos_right    <= 16'sd32767;
      sin_turn     <= '0;
      cos_turn     <= 16'sd32767;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOCAL:     focal_pixels <= cfg_data;
        REG_WORK_DIST: work_dist    <= cfg_data[19:0];
        REG_SIN_LEFT:  sin_left     <= cfg_data[15:0];
        REG_COS_LEFT:  cos_left     <= cfg_data[15:0];
        REG_SIN_RIGHT: sin_right    <= cfg_data[15:0];
        REG_COS_RIGHT: cos_right    <= cfg_data[15:0];
        REG_SIN_TURN:  sin_turn     <= cfg_data[15:0];
        REG_COS_TURN:  cos_turn     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid bits for the non-divider stages
  logic v0, v1, v2, v3, r0v, r1v, r2v, r3v, r4v, r5v, r6v;
  logic d1v, d2v;

  // S0: capture
  logic [PW-1:0]        s0_ax;
  logic signed [PW-1:0] s0_py;
  logic                 s0_side;
  // S1: products
  logic signed [40:0]    s1_fs;
  logic signed [PW+16:0] s1_ac;
  logic [PW+19:0]        s1_aw;
  logic signed [PW-1:0]  s1_py;
  logic                  s1_side;
  // S2: denominator
  logic [UNW-1:0]        s2_un;
  logic [DENW-1:0]       s2_ud;
  logic                  s2_neg, s2_dz, s2_side;
  logic signed [PW-1:0]  s2_py;
  // S3: biased numerator
  logic [N1W-1:0]        s3_n;
  logic [DENW-1:0]       s3_ud;
  logic [T1W-1:0]        s3_tag;

  logic signed [15:0] s1_sel_s, s1_sel_c;
  logic signed [DENW-1:0] s2_den_c;

  assign s1_sel_s = s0_side ? sin_right : sin_left;
  assign s1_sel_c = s0_side ? cos_right : cos_left;
  assign s2_den_c = DENW'(s1_fs) + (DENW'(s1_ac) <<< 8);

  always_ff @(posedge clk) begin
    s0_ax   <= pix_x[PW-1] ? PW'(-pix_x) : PW'(pix_x);
    s0_py   <= pix_y;
    s0_side <= right_side;

    s1_fs   <= $signed({1'b0, focal_pixels}) * s1_sel_s;
    s1_ac   <= $signed({1'b0, s0_ax}) * s1_sel_c;
    s1_aw   <= s0_ax * work_dist;
    s1_py   <= s0_py;
    s1_side <= s0_side;

    s2_un   <= {s1_aw, 23'b0};
    s2_ud   <= s2_den_c[DENW-1] ? DENW'(-s2_den_c) : DENW'(s2_den_c);
    s2_neg  <= s2_den_c[DENW-1];
    s2_dz   <= s2_den_c == '0;
    s2_side <= s1_side;
    s2_py   <= s1_py;

    s3_n    <= N1W'(s2_un) + N1W'(s2_ud >> 1);
    s3_ud   <= s2_ud;
    s3_tag  <= {s2_side, s2_py, s2_dz, s2_neg};
  end

  // range division
  logic [N1W-1:0] d1_q;
  logic [T1W-1:0] d1_tag;

  llpt_div #(.NW(N1W), .DW(DENW), .TW(T1W)) u_rho_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .num      (s3_n),
    .den      (s3_ud),
    .tag_in   (s3_tag),
    .out_valid(d1v),
    .quo      (d1_q),
    .tag_out  (d1_tag)
  );

  logic                 d1_side, d1_dz, d1_neg;
  logic signed [PW-1:0] d1_py;
  logic                 d1_over;
  logic [RHO_MW-1:0]    d1_mag;

  assign {d1_side, d1_py, d1_dz, d1_neg} = d1_tag;
  assign d1_over = |d1_q[N1W-1:RHO_MW];
  assign d1_mag  = d1_over ? {RHO_MW{1'b1}} : d1_q[RHO_MW-1:0];

  // R0..R6
  logic signed [RHO_W-1:0] r0_rho;
  logic signed [54:0]      r1_pc, r1_ps;
  logic signed [XY_W-1:0]  r2_x0, r2_y0;
  logic signed [55:0]      r3_xc, r3_ys, r3_xs, r3_yc;
  logic signed [40:0]      r3_wx;
  logic signed [56:0]      r4_rx, r4_ry;
  logic signed [ZPW-1:0]   r4_zp;
  logic signed [RND_OW-1:0] r5_rx, r5_ry;
  logic [ZNW-1:0]          r5_zm;
  logic                    r5_zneg;
  logic [N2W-1:0]          r6_n;
  logic [T2W-1:0]          r6_tag;

  logic                 r0_side, r1_side, r2_side, r3_side, r4_side, r5_side;
  logic                 r0_dz, r1_dz, r2_dz, r3_dz, r4_dz, r5_dz;
  logic                 r0_clip, r1_clip, r2_clip, r3_clip, r4_clip, r5_clip;
  logic signed [PW-1:0] r0_py, r1_py, r2_py, r3_py;

  logic signed [15:0]       r1_sel_s, r1_sel_c;
  logic signed [RND_OW-1:0] r2_yt;
  logic [ZPW-1:0]           r5_zabs;
  sat_t                     r6_sx, r6_sy;

  assign r1_sel_s = r0_side ? sin_right : sin_left;
  assign r1_sel_c = r0_side ? cos_right : cos_left;
  assign r2_yt    = rnd15(RND_IW'(r1_ps));
  assign r5_zabs  = r4_zp[ZPW-1] ? ZPW'(-r4_zp) : ZPW'(r4_zp);
  assign r6_sx    = sat24(r5_rx);
  assign r6_sy    = sat24(r5_ry);

  always_ff @(posedge clk) begin
    r0_rho  <= d1_neg ? -$signed({1'b0, d1_mag}) : $signed({1'b0, d1_mag});
    r0_side <= d1_side;
    r0_dz   <= d1_dz;
    r0_clip <= d1_over;
    r0_py   <= d1_py;

    r1_pc   <= r0_rho * r1_sel_c;
    r1_ps   <= r0_rho * r1_sel_s;
    r1_side <= r0_side;
    r1_dz   <= r0_dz;
    r1_clip <= r0_clip;
    r1_py   <= r0_py;

    r2_x0   <= XY_W'(rnd15(RND_IW'(r1_pc)));
    r2_y0   <= r1_side ? -XY_W'(r2_yt) : XY_W'(r2_yt);
    r2_side <= r1_side;
    r2_dz   <= r1_dz;
    r2_clip <= r1_clip;
    r2_py   <= r1_py;

    r3_xc   <= r2_x0 * cos_turn;
    r3_ys   <= r2_y0 * sin_turn;
    r3_xs   <= r2_x0 * sin_turn;
    r3_yc   <= r2_y0 * cos_turn;
    r3_wx   <= $signed({21'b0, work_dist}) - 41'(r2_x0);
    r3_side <= r2_side;
    r3_dz   <= r2_dz;
    r3_clip <= r2_clip;
    r3_py   <= r2_py;

    r4_rx   <= 57'(r3_xc) - 57'(r3_ys);
    r4_ry   <= 57'(r3_xs) + 57'(r3_yc);
    r4_zp   <= r3_py * r3_wx;
    r4_side <= r3_side;
    r4_dz   <= r3_dz;
    r4_clip <= r3_clip;

    r5_rx   <= rnd15(r4_rx);
    r5_ry   <= rnd15(r4_ry);
    r5_zm   <= {r5_zabs, 8'b0};
    r5_zneg <= r4_zp[ZPW-1];
    r5_side <= r4_side;
    r5_dz   <= r4_dz;
    r5_clip <= r4_clip;

    r6_n    <= N2W'(r5_zm) + N2W'(focal_pixels >> 1);
    r6_tag  <= {r6_sx.val, r6_sy.val, r5_side,
                r5_clip | r6_sx.clip | r6_sy.clip, r5_dz, r5_zneg};
  end

  // height division
  logic [N2W-1:0] d2_q;
  logic [T2W-1:0] d2_tag;

  llpt_div #(.NW(N2W), .DW(24), .TW(T2W)) u_z_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (r6v),
    .num      (r6_n),
    .den      (focal_pixels),
    .tag_in   (r6_tag),
    .out_valid(d2v),
    .quo      (d2_q),
    .tag_out  (d2_tag)
  );

  logic [OUT_W-1:0] d2_rx, d2_ry;
  logic             d2_side, d2_clip, d2_dz, d2_zneg;
  logic             z_big, z_over;
  logic [OUT_W-1:0] z_val;

  assign {d2_rx, d2_ry, d2_side, d2_clip, d2_dz, d2_zneg} = d2_tag;
  assign z_big  = |d2_q[N2W-1:OUT_W];
  assign z_over = d2_zneg ? (z_big || (d2_q[OUT_W-1] && |d2_q[OUT_W-2:0]))
                          : (z_big || d2_q[OUT_W-1]);

  always_comb begin
    if (focal_pixels == '0) begin
      z_val = '0;
    end else if (z_over) begin
      z_val = d2_zneg ? OUT_MIN[OUT_W-1:0] : OUT_MAX[OUT_W-1:0];
    end else begin
      z_val = d2_zneg ? -d2_q[OUT_W-1:0] : d2_q[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    side_out <= d2_side;
    if (d2_dz) begin
      point_x <= '0;
      point_y <= '0;
      point_z <= '0;
      clipped <= 1'b1;
    end else begin
      point_x <= d2_rx;
      point_y <= d2_ry;
      point_z <= z_val;
      clipped <= d2_clip | z_over | (focal_pixels == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      r0v  <= 1'b0;
      r1v  <= 1'b0;
      r2v  <= 1'b0;
      r3v  <= 1'b0;
      r4v  <= 1'b0;
      r5v  <= 1'b0;
      r6v  <= 1'b0;
      done <= 1'b0;
    end else begin
      v0   <= start && !busy;
      v1   <= v0;
      v2   <= v1;
      v3   <= v2;
      r0v  <= d1v;
      r1v  <= r0v;
      r2v  <= r1v;
      r3v  <= r2v;
      r4v  <= r3v;
      r5v  <= r4v;
      r6v  <= r5v;
      done <= d2v;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("request did not complete at the expected latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT) && side_out == $past(right_side, LAT))
    else $error("result without matching request");

  a_zero_focal: assert property (@(posedge clk) disable iff (rst)
    (done && focal_pixels == '0) |-> (clipped && point_z == '0))
    else $error("zero focal length not flagged");

endmodule
`default_nettype wire

### sv/llpt_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llpt_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// tag that travels alongside each request.
// ----------------------------------------------------------------------------
module llpt_div #(
  parameter int NW = 58,
  parameter int DW = 42,
  parameter int TW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [TW-1:0] tag_out
);

  logic          vld [1:NW];
  logic [DW-1:0] rem [1:NW];
  logic [NW-1:0] nq  [1:NW];
  logic [DW-1:0] dd  [1:NW];
  logic [TW-1:0] tg  [1:NW];

  for (genvar k = 1; k <= NW; k++) begin : g_stage
    logic          pv;
    logic [DW-1:0] pr;
    logic [NW-1:0] pn;
    logic [DW-1:0] pd;
    logic [TW-1:0] pt;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 1) begin : g_first
      assign pv = in_valid;
      assign pr = '0;
      assign pn = num;
      assign pd = den;
      assign pt = tag_in;
    end else begin : g_next
      assign pv = vld[k-1];
      assign pr = rem[k-1];
      assign pn = nq[k-1];
      assign pd = dd[k-1];
      assign pt = tg[k-1];
    end

    assign trial = {pr, pn[NW-1]};
    assign ge    = trial >= {1'b0, pd};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      rem[k] <= ge ? DW'(trial - {1'b0, pd}) : DW'(trial);
      nq[k]  <= {pn[NW-2:0], ge};
      dd[k]  <= pd;
      tg[k]  <= pt;
    end
  end

  assign out_valid = vld[NW];
  assign quo       = nq[NW];
  assign tag_out   = tg[NW];

endmodule
`default_nettype wire
